// ===== rtl/ray_box_slab_intersection_unit_macros.svh =====
// Assertion macros for the ray box slab intersection unit.
// Used by the checker module; depends on nothing else.
`ifndef RAY_BOX_SLAB_INTERSECTION_UNIT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RBSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsi assertion failed");

// Antecedent implies consequent in the following cycle.
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbsi assertion failed");

`endif

// ===== rtl/rbsi_pkg.sv =====
// Package for the ray box slab intersection unit: widths, face codes, lane types
// and the per-bit divider step. Depends on nothing.
`default_nettype none
package rbsi_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DIV_STEPS   = COORD_WIDTH + FRAC_BITS;
   localparam int NUM_AXES    = 3;
   localparam int NUM_LANES   = 2 * NUM_AXES;
   localparam int NUM_STAGES  = DIV_STEPS + 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORD_WIDTH-1:0]        mag_type;

   localparam coord_type T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam mag_type   CAP   = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      FACE_NONE    = 3'd0,
      FACE_PLUS_X  = 3'd1,
      FACE_MINUS_X = 3'd2,
      FACE_PLUS_Y  = 3'd3,
      FACE_MINUS_Y = 3'd4,
      FACE_PLUS_Z  = 3'd5,
      FACE_MINUS_Z = 3'd6
   } face_type;

   localparam face_type PLUS_FACE [NUM_AXES]  = '{FACE_PLUS_X, FACE_PLUS_Y, FACE_PLUS_Z};
   localparam face_type MINUS_FACE [NUM_AXES] = '{FACE_MINUS_X, FACE_MINUS_Y, FACE_MINUS_Z};

   typedef struct packed {
      mag_type num;
      mag_type den;
      mag_type rem;
      mag_type quo;
      logic    over;
      logic    neg;
   } lane_type;

   typedef struct packed {
      lane_type [NUM_LANES-1:0] lane;
      logic [NUM_AXES-1:0]      dzero;
      logic [NUM_AXES-1:0]      dneg;
      logic                     miss;
   } div_item_type;

   typedef struct packed {
      coord_type [NUM_LANES-1:0] t;
      logic [NUM_AXES-1:0]       dzero;
      logic [NUM_AXES-1:0]       dneg;
      logic                      miss;
   } fin_item_type;

   function automatic lane_type div_step(lane_type l);
      lane_type             r;
      logic [COORD_WIDTH:0] sh;
      logic [COORD_WIDTH:0] qn;
      logic                 qbit;
      r    = l;
      sh   = {l.rem, l.num[COORD_WIDTH-1]};
      qbit = 1'b0;
      r.num = {l.num[COORD_WIDTH-2:0], 1'b0};
      if (sh >= {1'b0, l.den}) begin
         r.rem = COORD_WIDTH'(sh - {1'b0, l.den});
         qbit  = 1'b1;
      end else begin
         r.rem = sh[COORD_WIDTH-1:0];
      end
      qn = {l.quo, qbit};
      if (!l.over) begin
         if (qn > {1'b0, CAP}) begin
            r.over = 1'b1;
         end else begin
            r.quo = qn[COORD_WIDTH-1:0];
         end
      end
      return r;
   endfunction

   function automatic coord_type lane_t(lane_type l);
      mag_type mag;
      mag = l.over ? CAP : l.quo;
      if (l.neg) begin
         return coord_type'(~mag + mag_type'(1));
      end else if (mag > mag_type'(T_MAX)) begin
         return T_MAX;
      end
      return coord_type'(mag);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/rbsi_req_if.sv =====
// Request channel of the ray box slab intersection unit: box, start and direction.
// Depends on rbsi_pkg.
`default_nettype none
interface rbsi_req_if;
   import rbsi_pkg::*;
   logic      valid;
   logic      ready;
   coord_type box_min_x;
   coord_type box_min_y;
   coord_type box_min_z;
   coord_type box_max_x;
   coord_type box_max_y;
   coord_type box_max_z;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type dir_x;
   coord_type dir_y;
   coord_type dir_z;
   modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                   box_max_z, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                 box_max_z, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/rbsi_rsp_if.sv =====
// Response channel of the ray box slab intersection unit: hit, parameters and faces.
// Depends on rbsi_pkg.
`default_nettype none
interface rbsi_rsp_if;
   import rbsi_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [COORD_WIDTH-2:0] t_enter;
   coord_type              t_exit;
   face_type               enter_face;
   face_type               exit_face;
   modport source (output valid, hit, t_enter, t_exit, enter_face, exit_face, input ready);
   modport sink (input valid, hit, t_enter, t_exit, enter_face, exit_face, output ready);
endinterface
`default_nettype wire

// ===== rtl/ray_box_slab_intersection_unit.sv =====
// Top level of the ray box slab intersection unit: pipelined slab test in Q16.16.
// Depends on rbsi_pkg, rbsi_req_if and rbsi_rsp_if.
//
//   Channel   Direction   Contents
//   req_port  in          box corners, ray start and direction
//   rsp_port  out         hit, entry and exit parameters, entry and exit faces
//
// One request is accepted per cycle unless the pipeline stalls. It has an input stage,
// one stage per quotient bit of the six slab dividers, a conversion stage and an
// output register. Reset clears every stage's valid bit; data registers are not reset.
// Each stage holds while its successor is full and stalled, so bubbles close up.
`default_nettype none
module ray_box_slab_intersection_unit (
   input wire logic   clock,
   input wire logic   reset,
   rbsi_req_if.sink   req_port,
   rbsi_rsp_if.source rsp_port
);
   import rbsi_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;
   div_item_type          div_ff [DIV_STEPS+1];
   div_item_type          div_in;
   fin_item_type          fin_ff;
   fin_item_type          fin_in;
   logic                  hit_ff, hit_in;
   coord_type             tmin_ff, tmin_in;
   coord_type             tmax_ff, tmax_in;
   face_type              enter_face_ff, enter_face_in;
   face_type              exit_face_ff, exit_face_in;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_port.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_port.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_port.valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      coord_type                lo [NUM_AXES];
      coord_type                hi [NUM_AXES];
      coord_type                st [NUM_AXES];
      coord_type                dr [NUM_AXES];
      coord_type                cn;
      logic signed [COORD_WIDTH:0] diff;
      lo = '{req_port.box_min_x, req_port.box_min_y, req_port.box_min_z};
      hi = '{req_port.box_max_x, req_port.box_max_y, req_port.box_max_z};
      st = '{req_port.start_x, req_port.start_y, req_port.start_z};
      dr = '{req_port.dir_x, req_port.dir_y, req_port.dir_z};
      div_in = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         div_in.dzero[a] = (dr[a] == '0);
         div_in.dneg[a]  = dr[a][COORD_WIDTH-1];
         if (div_in.dzero[a] && ((st[a] < lo[a]) || (st[a] > hi[a]))) begin
            div_in.miss = 1'b1;
         end
         for (int k = 0; k < 2; k++) begin
            cn   = ((k == 0) == div_in.dneg[a]) ? hi[a] : lo[a];
            diff = {cn[COORD_WIDTH-1], cn} - {st[a][COORD_WIDTH-1], st[a]};
            if (diff[COORD_WIDTH]) begin
               div_in.lane[2*a+k].num = COORD_WIDTH'(-diff);
            end else begin
               div_in.lane[2*a+k].num = diff[COORD_WIDTH-1:0];
            end
            div_in.lane[2*a+k].den = div_in.dneg[a] ? mag_type'(-dr[a]) : mag_type'(dr[a]);
            div_in.lane[2*a+k].neg = diff[COORD_WIDTH] ^ div_in.dneg[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         div_ff[0] <= div_in;
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
      div_item_type step_in;
      always_comb begin
         step_in = div_ff[s-1];
         for (int j = 0; j < NUM_LANES; j++) begin
            step_in.lane[j] = div_step(div_ff[s-1].lane[j]);
         end
      end
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            div_ff[s] <= step_in;
         end
      end
   end

   always_comb begin
      fin_in.dzero = div_ff[DIV_STEPS].dzero;
      fin_in.dneg  = div_ff[DIV_STEPS].dneg;
      fin_in.miss  = div_ff[DIV_STEPS].miss;
      for (int j = 0; j < NUM_LANES; j++) begin
         fin_in.t[j] = lane_t(div_ff[DIV_STEPS].lane[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_STEPS+1]) begin
         fin_ff <= fin_in;
      end
   end

   always_comb begin
      tmin_in       = '0;
      tmax_in       = T_MAX;
      enter_face_in = FACE_NONE;
      exit_face_in  = FACE_NONE;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (!fin_ff.dzero[a]) begin
            if (tmin_in < fin_ff.t[2*a]) begin
               tmin_in       = fin_ff.t[2*a];
               enter_face_in = fin_ff.dneg[a] ? PLUS_FACE[a] : MINUS_FACE[a];
            end
            if (tmax_in > fin_ff.t[2*a+1]) begin
               tmax_in      = fin_ff.t[2*a+1];
               exit_face_in = fin_ff.dneg[a] ? MINUS_FACE[a] : PLUS_FACE[a];
            end
         end
      end
      hit_in = !fin_ff.miss && (tmin_in < tmax_in);
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         hit_ff        <= hit_in;
         tmin_ff       <= tmin_in;
         tmax_ff       <= tmax_in;
         enter_face_ff <= enter_face_in;
         exit_face_ff  <= exit_face_in;
      end
   end

   assign rsp_port.valid      = vld_ff[NUM_STAGES-1];
   assign rsp_port.hit        = hit_ff;
   assign rsp_port.t_enter    = tmin_ff[COORD_WIDTH-2:0];
   assign rsp_port.t_exit     = tmax_ff;
   assign rsp_port.enter_face = enter_face_ff;
   assign rsp_port.exit_face  = exit_face_ff;
endmodule
`default_nettype wire

// ===== rtl/rbsi_checker.sv =====
// Port checker for the ray box slab intersection unit, with its bind statement.
// Depends on rbsi_pkg and ray_box_slab_intersection_unit_macros.svh.
`default_nettype none
`include "ray_box_slab_intersection_unit_macros.svh"
module rbsi_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_hit,
   input wire logic [rbsi_pkg::COORD_WIDTH-2:0] rsp_t_enter,
   input wire rbsi_pkg::coord_type             rsp_t_exit,
   input wire rbsi_pkg::face_type              rsp_enter_face,
   input wire rbsi_pkg::face_type              rsp_exit_face
);
   import rbsi_pkg::*;

   `RBSI_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RBSI_ASSERT_SAME(a_hit_order, clock, reset, rsp_valid && rsp_hit, $signed({1'b0, rsp_t_enter}) < rsp_t_exit)
   `RBSI_ASSERT_SAME(a_no_exit_face, clock, reset, rsp_valid && (rsp_exit_face == FACE_NONE), rsp_t_exit == T_MAX)
   `RBSI_ASSERT_SAME(a_no_enter_face, clock, reset, rsp_valid && (rsp_enter_face == FACE_NONE), rsp_t_enter == '0)
endmodule

bind ray_box_slab_intersection_unit rbsi_checker u_rbsi_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_hit        (rsp_port.hit),
   .rsp_t_enter    (rsp_port.t_enter),
   .rsp_t_exit     (rsp_port.t_exit),
   .rsp_enter_face (rsp_port.enter_face),
   .rsp_exit_face  (rsp_port.exit_face)
);
`default_nettype wire
